@@ src/assert_macros.svh @@
// Assertion macros for the skip filter index table RTL, used by sfit_engine.
// Each macro samples on the rising edge of clock; no other dependency.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while reset is low.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Check a property at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

@@ src/sfit_pkg.sv @@
// Shared types and constants for the skip filter index table.
// No dependencies; used by sfit_engine and skip_filter_index_table.
package sfit_pkg;

   // Default table depth (ids 1 .. ID_COUNT-1 are tracked)
   localparam int ID_COUNT_DEFAULT = 1024;

   // Fixed field widths
   localparam int OP_W     = 2;
   localparam int ID_W     = 10;
   localparam int ANSWER_W = 11;
   localparam int TOTAL_W  = 10;

   // Status codes
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_ZERO_ID = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_FILTER        = 2'd0,
      OP_NEXT          = 2'd1,
      OP_NEXT_FILTERED = 2'd2,
      OP_QUERY         = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_SUCC,
      S_WALK,
      S_NEXT,
      S_SCAN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [ANSWER_W-1:0] answer_id;
      logic                is_filtered;
      logic [TOTAL_W-1:0]  filtered_total;
      logic                status;
   } result_type;

endpackage

@@ src/skip_filter_index_table.sv @@
// Top level of the skip filter index table: engine, table memory, result register.
// Depends on sfit_pkg, sfit_table_ram and sfit_engine.
//
//   channel | dir | tdata (low bit up)                         | tuser
//   req     | in  | item_id[9:0], zero fill to 16 bits         | operation[1:0]
//   rsp     | out | answer_id[10:0], is_filtered, filtered_total[9:0], zero fill to 24 | status
//
// After reset a clearing pass over every entry loads entry i with i+1; req_tready stays low.
// One item at a time; each step is one table read. A zero id for a filter or query, or an
// out-of-range id, reads no entry; lookups, queries and refilters read one, a filter two plus
// one per entry walked (about one per repointed entry), next-filtered one per entry scanned.
// A result waits in the rsp register while the next item is accepted and worked on;
// a stalled rsp holds the engine only when it has another result ready.
module skip_filter_index_table #(
   parameter int ID_COUNT = sfit_pkg::ID_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // item_id[9:0], zero [15:10]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // answer_id[10:0], is_filtered[11], filtered_total[21:12]
   output logic [0:0]  rsp_tuser    // status[0]
);

   localparam int AW = $clog2(ID_COUNT);
   localparam int DW = $clog2(ID_COUNT + 1);

   logic                 mem_we, mem_re;
   logic [AW-1:0]        mem_waddr, mem_raddr;
   logic [DW-1:0]        mem_wdata, mem_rdata;
   logic                 res_valid, res_take;
   sfit_pkg::result_type res;
   logic                 rsp_valid_ff, rsp_valid_in;
   sfit_pkg::result_type rsp_res_ff, rsp_res_in;

   sfit_engine #(
      .ID_COUNT (ID_COUNT),
      .AW       (AW),
      .DW       (DW)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (req_tuser),
      .req_id    (req_tdata[sfit_pkg::ID_W-1:0]),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res       (res),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   sfit_table_ram #(
      .DEPTH (ID_COUNT),
      .AW    (AW),
      .DW    (DW)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Load the result register when it is empty or being drained
   assign res_take = res_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_res_ff.filtered_total, rsp_res_ff.is_filtered,
                        rsp_res_ff.answer_id};
   assign rsp_tuser  = rsp_res_ff.status;

endmodule

@@ src/sfit_table_ram.sv @@
// Simple dual-port table memory: one write and one registered read per cycle.
// No package dependency; sized by the parent.
module sfit_table_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int DW    = 11
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/sfit_engine.sv @@
// Sequencer for the skip filter index table: clearing pass, lookups, walks
// and scans over the table memory. Depends on sfit_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sfit_engine #(
   parameter int ID_COUNT = sfit_pkg::ID_COUNT_DEFAULT,
   parameter int AW       = $clog2(ID_COUNT),
   parameter int DW       = $clog2(ID_COUNT + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   // request side
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [sfit_pkg::OP_W-1:0]    req_op,
   input  logic [sfit_pkg::ID_W-1:0]    req_id,
   // result side
   output logic                         res_valid,
   input  logic                         res_take,
   output sfit_pkg::result_type         res,
   // table memory
   output logic                         mem_we,
   output logic [AW-1:0]                mem_waddr,
   output logic [DW-1:0]                mem_wdata,
   output logic                         mem_re,
   output logic [AW-1:0]                mem_raddr,
   input  logic [DW-1:0]                mem_rdata
);

   localparam int IDW   = sfit_pkg::ID_W;
   localparam int ANS_W = sfit_pkg::ANSWER_W;
   localparam int TOT_W = sfit_pkg::TOTAL_W;
   localparam int EW    = ((AW > IDW) ? AW : IDW) + 1;
   localparam logic [EW-1:0] ID_LIMIT  = EW'(ID_COUNT);
   localparam logic [AW-1:0] LAST_ADDR = AW'(ID_COUNT - 1);

   sfit_pkg::state_type state_ff, state_in;
   sfit_pkg::op_type    op_ff, op_in, req_kind;
   logic [IDW-1:0]      id_ff, id_in;
   logic [AW-1:0]       addr_ff, addr_in;
   logic [DW-1:0]       succ_ff, succ_in;
   logic [TOT_W-1:0]    count_ff, count_in;
   logic [ANS_W-1:0]    answer_ff, answer_in;
   logic                flag_ff, flag_in;
   logic                status_ff, status_in;

   logic [EW-1:0] req_id_ext, id_ext, rdata_ext, addr_ext;
   logic          req_zero, req_in_range, req_needs_id;
   logic          chk_filtered, walk_hit, scan_hit, addr_last, addr_zero;

   // Decode the incoming item and the entry just read
   assign req_kind     = sfit_pkg::op_type'(req_op);
   assign req_id_ext   = EW'(req_id);
   assign req_zero     = (req_id == '0);
   assign req_in_range = (req_id_ext < ID_LIMIT);
   assign req_needs_id = (req_kind == sfit_pkg::OP_FILTER) || (req_kind == sfit_pkg::OP_QUERY);
   assign id_ext       = EW'(id_ff);
   assign rdata_ext    = EW'(mem_rdata);
   assign addr_ext     = EW'(addr_ff);
   assign chk_filtered = (rdata_ext != id_ext);
   assign walk_hit     = (rdata_ext == id_ext);
   assign scan_hit     = (rdata_ext != (addr_ext + EW'(1)));
   assign addr_last    = (addr_ff == LAST_ADDR);
   assign addr_zero    = (addr_ff == '0);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sfit_pkg::S_CLEAR: begin
            if (addr_last) state_in = sfit_pkg::S_IDLE;
         end
         sfit_pkg::S_IDLE: begin
            if (req_valid) begin
               case (req_kind)
                  sfit_pkg::OP_NEXT: begin
                     state_in = req_in_range ? sfit_pkg::S_NEXT : sfit_pkg::S_DONE;
                  end
                  sfit_pkg::OP_NEXT_FILTERED: begin
                     state_in = req_in_range ? sfit_pkg::S_SCAN : sfit_pkg::S_DONE;
                  end
                  default: begin
                     state_in = (req_zero || !req_in_range) ? sfit_pkg::S_DONE
                                                            : sfit_pkg::S_CHECK;
                  end
               endcase
            end
         end
         sfit_pkg::S_CHECK: begin
            state_in = (op_ff == sfit_pkg::OP_QUERY || chk_filtered) ? sfit_pkg::S_DONE
                                                                     : sfit_pkg::S_SUCC;
         end
         sfit_pkg::S_SUCC: begin
            state_in = addr_zero ? sfit_pkg::S_DONE : sfit_pkg::S_WALK;
         end
         sfit_pkg::S_WALK: begin
            if (!walk_hit || addr_zero) state_in = sfit_pkg::S_DONE;
         end
         sfit_pkg::S_NEXT: begin
            state_in = sfit_pkg::S_DONE;
         end
         sfit_pkg::S_SCAN: begin
            if (scan_hit || addr_last) state_in = sfit_pkg::S_DONE;
         end
         sfit_pkg::S_DONE: begin
            if (res_take) state_in = sfit_pkg::S_IDLE;
         end
         default: begin
            state_in = sfit_pkg::S_CLEAR;
         end
      endcase
   end

   // Memory controls and datapath
   always_comb begin
      req_ready = 1'b0;
      res_valid = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = succ_ff;
      mem_re    = 1'b0;
      mem_raddr = addr_ff;
      op_in     = op_ff;
      id_in     = id_ff;
      addr_in   = addr_ff;
      succ_in   = succ_ff;
      count_in  = count_ff;
      answer_in = answer_ff;
      flag_in   = flag_ff;
      status_in = status_ff;
      case (state_ff)
         sfit_pkg::S_CLEAR: begin
            // write the identity successor into each entry
            mem_we    = 1'b1;
            mem_wdata = DW'(addr_ff) + DW'(1);
            addr_in   = addr_ff + AW'(1);
         end
         sfit_pkg::S_IDLE: begin
            req_ready = 1'b1;
            op_in     = req_kind;
            id_in     = req_id;
            answer_in = '0;
            flag_in   = 1'b0;
            status_in = (req_needs_id && req_zero) ? sfit_pkg::STATUS_ZERO_ID
                                                   : sfit_pkg::STATUS_OK;
            if (req_needs_id) begin
               addr_in = AW'(req_id_ext - EW'(1));
            end else begin
               addr_in = AW'(req_id_ext);
            end
            if (req_kind == sfit_pkg::OP_NEXT && !req_in_range) begin
               answer_in = ANS_W'(req_id_ext + EW'(1));
            end
            mem_raddr = addr_in;
            mem_re    = req_valid && req_in_range && !(req_needs_id && req_zero);
         end
         sfit_pkg::S_CHECK: begin
            // entry id-1 is back; fetch the successor if a filter finds the id still live
            if (op_ff == sfit_pkg::OP_QUERY || chk_filtered) begin
               flag_in = chk_filtered;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = addr_ff + AW'(1);
            end
         end
         sfit_pkg::S_SUCC: begin
            // repoint entry id-1 and start the backward walk
            succ_in   = mem_rdata;
            count_in  = count_ff + TOT_W'(1);
            mem_we    = 1'b1;
            mem_wdata = mem_rdata;
            if (!addr_zero) begin
               mem_re    = 1'b1;
               mem_raddr = addr_ff - AW'(1);
               addr_in   = addr_ff - AW'(1);
            end
         end
         sfit_pkg::S_WALK: begin
            if (walk_hit) begin
               mem_we = 1'b1;
               if (!addr_zero) begin
                  mem_re    = 1'b1;
                  mem_raddr = addr_ff - AW'(1);
                  addr_in   = addr_ff - AW'(1);
               end
            end
         end
         sfit_pkg::S_NEXT: begin
            answer_in = ANS_W'(rdata_ext);
         end
         sfit_pkg::S_SCAN: begin
            // advance one entry a cycle until a repointed entry shows up or the last entry is read
            if (scan_hit) begin
               answer_in = ANS_W'(addr_ext + EW'(1));
            end else if (!addr_last) begin
               mem_re    = 1'b1;
               mem_raddr = addr_ff + AW'(1);
               addr_in   = addr_ff + AW'(1);
            end
         end
         sfit_pkg::S_DONE: begin
            res_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign res.answer_id      = answer_ff;
   assign res.is_filtered    = flag_ff;
   assign res.filtered_total = count_ff;
   assign res.status         = status_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sfit_pkg::S_CLEAR;
         addr_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         count_ff <= count_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      id_ff     <= id_in;
      succ_ff   <= succ_in;
      answer_ff <= answer_in;
      flag_ff   <= flag_in;
      status_ff <= status_in;
   end

   `ASSERT_CLK(a_write_states, mem_we |-> (state_ff == sfit_pkg::S_CLEAR || state_ff == sfit_pkg::S_SUCC || state_ff == sfit_pkg::S_WALK), "table written outside clear, repoint or walk")
   `ASSERT_CLK(a_count_hold, (state_ff != sfit_pkg::S_SUCC) |=> (count_ff == $past(count_ff)), "filtered count moved outside repoint")
   `ASSERT_CLK(a_walk_match, (state_ff == sfit_pkg::S_WALK && mem_we) |-> (rdata_ext == id_ext), "walk repointed an entry that did not point to the id")
   `ASSERT_CLK(a_accept_leaves_idle, (state_ff == sfit_pkg::S_IDLE && req_valid) |=> (state_ff != sfit_pkg::S_IDLE), "accepted item did not start work")

endmodule

@@ verif/tb_skip_filter_index_table.sv @@
// Testbench for skip_filter_index_table: directed and random filter, lookup and query items,
// checked field by field against a predictor of the skip table kept in the testbench.
// Depends on sfit_pkg and the skip_filter_index_table RTL.
module tb_skip_filter_index_table;
   timeunit 1ns;
   timeprecision 1ps;
   import sfit_pkg::*;

   localparam int TABLE_DEPTH  = ID_COUNT_DEFAULT;
   localparam int STALL_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      op_type          op;
      logic [ID_W-1:0] id;
      result_type      res;
   } expected_answer;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;    // item_id[9:0], zero [15:10]
   logic [1:0]  req_tuser  = '0;    // operation[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;          // answer_id[10:0], is_filtered[11], filtered_total[21:12]
   logic [0:0]  rsp_tuser;          // status[0]

   // predicted table: entry i holds the next unfiltered id after i
   logic [ANSWER_W-1:0] skip_next [TABLE_DEPTH];
   logic [TOTAL_W-1:0]  filtered_tally;

   expected_answer pending_answers[$];
   int             mismatch_count = 0;
   int             stall_cycles   = 0;
   int             recent_id      = 1;
   bit             steady_flow    = 1'b0;

   skip_filter_index_table #(.ID_COUNT(TABLE_DEPTH)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // an id is filtered once the entry below it no longer points to it
   function automatic logic id_filtered(int id);
      return id != 0 && skip_next[id-1] != id;
   endfunction

   // advance the predicted table by one item and return its result
   function automatic result_type apply_item(op_type op, logic [ID_W-1:0] id);
      result_type          res;
      logic [ANSWER_W-1:0] succ;
      int                  i;
      res = '0;
      case (op)
         OP_FILTER: begin
            if (id == 0) begin
               res.status = STATUS_ZERO_ID;
            end else if (id_filtered(id)) begin
               res.is_filtered = 1'b1;
            end else begin
               succ = skip_next[id];
               filtered_tally = filtered_tally + 1'b1;
               // repoint the run below the id to its successor
               i = id;
               while (i > 0 && skip_next[i-1] == id) begin
                  skip_next[i-1] = succ;
                  i--;
               end
            end
         end
         OP_NEXT: begin
            res.answer_id = skip_next[id];
         end
         OP_NEXT_FILTERED: begin
            for (i = id; i < TABLE_DEPTH && res.answer_id == 0; i++)
               if (skip_next[i] != i + 1) res.answer_id = i + 1;
         end
         default: begin
            if (id == 0) res.status = STATUS_ZERO_ID;
            else res.is_filtered = id_filtered(id);
         end
      endcase
      res.filtered_total = filtered_tally;
      return res;
   endfunction

   task automatic report_mismatch(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(string field, int got, int want, expected_answer w);
      if (got != want)
         report_mismatch($sformatf("%s for %s id %0d: got %0d expected %0d",
                                   field, w.op.name(), w.id, got, want));
   endtask

   // hold the item until accepted, then record its predicted result
   task automatic send_item(op_type op, logic [ID_W-1:0] id);
      expected_answer entry;
      while (!steady_flow && $urandom_range(0, 99) < 37) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, id};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      entry.op  = op;
      entry.id  = id;
      entry.res = apply_item(op, id);
      pending_answers.push_back(entry);
      if (op == OP_FILTER && id != 0) recent_id = id;
   endtask

   function automatic op_type pick_op();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 35) return OP_FILTER;
      if (roll < 55) return OP_NEXT;
      if (roll < 75) return OP_NEXT_FILTERED;
      return OP_QUERY;
   endfunction

   // some ids near recent filters, some extremes, most spread out
   function automatic logic [ID_W-1:0] pick_id();
      int roll;
      int pick;
      roll = $urandom_range(0, 15);
      if (roll == 0) pick = 0;
      else if (roll == 1) pick = TABLE_DEPTH - 1;
      else if (roll < 7) pick = recent_id - 3 + int'($urandom_range(0, 6));
      else pick = $urandom_range(1, TABLE_DEPTH - 1);
      if (pick < 0) pick = 0;
      if (pick > TABLE_DEPTH - 1) pick = TABLE_DEPTH - 1;
      return pick[ID_W-1:0];
   endfunction

   // extremes, every operation, zero id, refiltering and run repointing
   task automatic test_directed();
      send_item(OP_QUERY, 0);
      send_item(OP_FILTER, 0);
      send_item(OP_NEXT, 0);
      send_item(OP_NEXT_FILTERED, 0);
      send_item(OP_NEXT, 1023);
      send_item(OP_NEXT_FILTERED, 1023);
      send_item(OP_FILTER, 1023);
      send_item(OP_QUERY, 1023);
      send_item(OP_FILTER, 1023);
      send_item(OP_NEXT_FILTERED, 0);
      send_item(OP_NEXT, 1022);
      send_item(OP_FILTER, 1);
      send_item(OP_FILTER, 2);
      send_item(OP_FILTER, 3);
      send_item(OP_NEXT, 0);
      send_item(OP_NEXT_FILTERED, 0);
      send_item(OP_QUERY, 2);
      send_item(OP_FILTER, 512);
      send_item(OP_NEXT_FILTERED, 4);
      send_item(OP_QUERY, 511);
      send_item(OP_NEXT, 511);
      send_item(OP_FILTER, 511);
      send_item(OP_NEXT, 510);
      send_item(OP_FILTER, 510);
      send_item(OP_NEXT, 509);
   endtask

   task automatic test_random_mix(int count);
      for (int n = 0; n < count; n++)
         send_item(pick_op(), pick_id());
   endtask

   // filter contiguous runs up or down, then look around them
   task automatic test_filter_runs(int runs);
      int start;
      int len;
      int step;
      int id;
      for (int r = 0; r < runs; r++) begin
         start = $urandom_range(1, TABLE_DEPTH - 1);
         len   = $urandom_range(2, 12);
         step  = $urandom_range(0, 1) ? 1 : -1;
         id    = start;
         for (int k = 0; k < len && id >= 1 && id < TABLE_DEPTH; k++) begin
            send_item(OP_FILTER, id);
            if ($urandom_range(0, 4) == 0) send_item(pick_op(), pick_id());
            id += step;
         end
         id = (step > 0) ? start : start - len;
         if (id < 0) id = 0;
         send_item(OP_NEXT, id);
         send_item(OP_NEXT_FILTERED, id);
         send_item(OP_QUERY, start);
      end
   endtask

   task automatic test_steady(int count);
      steady_flow = 1'b1;
      test_random_mix(count);
      steady_flow = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < TABLE_DEPTH; i++) skip_next[i] = i + 1;
      filtered_tally = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_mix(650);
      test_filter_runs(30);
      test_steady(300);

      // drop valid and drain the remaining results
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS skip_filter_index_table");
      end else begin
         $display("FAIL skip_filter_index_table");
      end
      $finish;
   end

   // check each result, randomize backpressure, watch for a hang
   always @(posedge clock) begin : check_results
      expected_answer want;
      result_type     got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.answer_id      = rsp_tdata[10:0];
         got.is_filtered    = rsp_tdata[11];
         got.filtered_total = rsp_tdata[21:12];
         got.status         = rsp_tuser[0];
         if (pending_answers.size() == 0) begin
            report_mismatch("result with no item pending");
         end else begin
            want = pending_answers.pop_front();
            compare_field("answer_id", got.answer_id, want.res.answer_id, want);
            compare_field("is_filtered", got.is_filtered, want.res.is_filtered, want);
            compare_field("filtered_total", got.filtered_total, want.res.filtered_total, want);
            compare_field("status", got.status, want.res.status, want);
         end
      end
      rsp_tready <= steady_flow || ($urandom_range(0, 99) >= 37);

      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
         $display("FAIL skip_filter_index_table");
         $finish;
      end
   end

endmodule

@@ skip_filter_index_table.f @@
+incdir+src
src/sfit_pkg.sv
src/sfit_table_ram.sv
src/sfit_engine.sv
src/skip_filter_index_table.sv
verif/tb_skip_filter_index_table.sv
